[design/scli_pkg.sv]
// Shared types, constants and state encoding for the sorted candidate list.
package scli_pkg;

  localparam int ModeW         = 8;
  localparam int CostW         = 40;
  localparam int RankW         = 3;
  localparam int KeepW         = 4;
  localparam int MaxCandidates = 8;
  localparam int OutLimit      = 8;
  localparam int DataW         = 32;
  localparam int AddrW         = 3;

  localparam logic [KeepW-1:0] KeepReset = 4'd8;

  // register index, taken from paddr above the byte offset
  localparam logic RegKeepCount = 1'b0;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CostW-1:0] cost;
    logic             end_of_block;
  } in_word_t;

  typedef struct packed {
    logic [RankW-1:0] rank;
    logic [ModeW-1:0] best_mode;
    logic [CostW-1:0] best_cost;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [CostW-1:0] cost;
  } slot_t;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StPut,
    StEmit
  } ctrl_state_e;

endpackage

[design/scli_slot_ram.sv]
// Slot memory: one write port, one read port, registered read data.
module scli_slot_ram
  import scli_pkg::*;
#(
  parameter int Depth = MaxCandidates,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  slot_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output slot_t         rdata_o
);

  slot_t mem_q [Depth];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/scli_cfg_regs.sv]
// Configuration register file behind the APB-style port.
module scli_cfg_regs
  import scli_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [KeepW-1:0] keep_count_o
);

  logic [KeepW-1:0] keep_q, keep_d;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == RegKeepCount);

  always_comb begin
    keep_d = keep_q;
    if (wr_en) begin
      keep_d = pwdata[KeepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KeepReset;
    end else begin
      keep_q <= keep_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegKeepCount) begin
      prdata = {{(DataW-KeepW){1'b0}}, keep_q};
    end
  end

  assign keep_count_o = keep_q;

endmodule

[design/scli_insert_ctrl.sv]
// Insertion walk and list read-out sequencer around the slot memory.
module scli_insert_ctrl
  import scli_pkg::*;
#(
  parameter int Depth = MaxCandidates,
  localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [KeepW-1:0] keep_count_i,
  input  logic             start_i,
  input  in_word_t         in_word_i,
  output logic             busy_o,
  output logic             out_valid_o,
  output out_word_t        out_word_o,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output slot_t            mem_wdata_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_raddr_o,
  input  slot_t            mem_rdata_i
);

  localparam int CapLimit = (Depth < OutLimit) ? Depth : OutLimit;

  ctrl_state_e      state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    emit_q, emit_d;
  logic             chk_q, chk_d;
  logic             eob_q, eob_d;
  logic [CntW-1:0]  filled_q, filled_d;
  slot_t            new_q, new_d;
  logic             out_valid_q, out_valid_d;
  logic [RankW-1:0] rank_q, rank_d;
  logic             last_q, last_d;

  logic [KeepW-1:0] keep_lim;
  logic [CntW-1:0]  cap;
  logic [CntW-1:0]  n;
  logic             gt;
  logic             emit_last;
  ctrl_state_e      fin_state;

  // clamp the retained size to 1..min(OutLimit, Depth)
  always_comb begin
    keep_lim = keep_count_i;
    if (keep_count_i == '0) begin
      keep_lim = KeepW'(1);
    end else if (keep_count_i > KeepW'(CapLimit)) begin
      keep_lim = KeepW'(CapLimit);
    end
  end

  assign cap       = CntW'(keep_lim);
  assign n         = (filled_q > cap) ? cap : filled_q;
  assign gt        = mem_rdata_i.cost > new_q.cost;
  assign emit_last = (CntW'(emit_q) + CntW'(1)) == filled_q;
  assign fin_state = eob_q ? StEmit : StIdle;

  // next state
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    emit_d   = emit_q;
    chk_d    = chk_q;
    eob_d    = eob_q;
    filled_d = filled_q;
    new_d    = new_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          new_d.mode = in_word_i.mode;
          new_d.cost = in_word_i.cost;
          eob_d      = in_word_i.end_of_block;
          emit_d     = '0;
          filled_d   = (n < cap) ? n + CntW'(1) : cap;
          if (n == '0) begin
            idx_d   = '0;
            state_d = StPut;
          end else if (n < cap) begin
            idx_d   = AW'(n);
            chk_d   = 1'b0;
            state_d = StCmp;
          end else begin
            // full: test the worst entry before anything moves
            idx_d   = AW'(cap - CntW'(1));
            chk_d   = 1'b1;
            state_d = StCmp;
          end
        end
      end
      StCmp: begin
        if (chk_q) begin
          if (!gt) begin
            state_d = fin_state;
          end else begin
            chk_d   = 1'b0;
            state_d = (idx_q == '0) ? StPut : StCmp;
          end
        end else if (gt) begin
          idx_d   = idx_q - AW'(1);
          state_d = (idx_q == AW'(1)) ? StPut : StCmp;
        end else begin
          state_d = fin_state;
        end
      end
      StPut: begin
        state_d = fin_state;
      end
      StEmit: begin
        emit_d = emit_q + AW'(1);
        if (emit_last) begin
          filled_d = '0;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // memory accesses and result word
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = new_q;
    out_valid_d = 1'b0;
    rank_d      = rank_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (start_i && (n != '0)) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = (n < cap) ? AW'(n - CntW'(1)) : AW'(cap - CntW'(1));
        end
      end
      StCmp: begin
        if (chk_q) begin
          if (gt && (idx_q != '0)) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q - AW'(1);
          end
        end else begin
          // write slot idx while reading idx-2: never the same entry
          mem_we_o    = 1'b1;
          mem_wdata_o = gt ? mem_rdata_i : new_q;
          if (gt && (idx_q != AW'(1))) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_q - AW'(2);
          end
        end
      end
      StPut: begin
        mem_we_o = 1'b1;
      end
      StEmit: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = emit_q;
        out_valid_d = 1'b1;
        rank_d      = RankW'(emit_q);
        last_d      = emit_last;
      end
      default: begin
        mem_re_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      filled_q    <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      emit_q      <= '0;
      chk_q       <= 1'b0;
      eob_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      emit_q      <= emit_d;
      chk_q       <= chk_d;
      eob_q       <= eob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q  <= new_d;
    rank_q <= rank_d;
    last_q <= last_d;
  end

  assign busy_o                = (state_q != StIdle);
  assign out_valid_o           = out_valid_q;
  assign out_word_o.rank       = rank_q;
  assign out_word_o.best_mode  = mem_rdata_i.mode;
  assign out_word_o.best_cost  = mem_rdata_i.cost;
  assign out_word_o.last       = last_q;

endmodule

[design/sorted_candidate_list_insert_unit.sv]
// Sorted candidate list: usage notes
// Keeps up to keep_count mode candidates sorted by ascending cost; ties keep
// their arrival order and the worst entry drops off a full list.
// Input channel: a word on in_word_i is taken at an edge where start_i is
// high and busy_o is low. Insertion walks the slot memory from the tail,
// one slot per cycle through its single read port and single write port;
// keep_count is held to 1..min(8, MAX_CANDIDATES), and a word rejected
// by a full list is dropped after one comparison with the worst entry.
// A word with end_of_block set is inserted first, then the list is read
// out best first, one word per cycle on out_word_o with out_valid_o, rank
// counting from 0 and last on the final word, after which the list is
// empty. Busy stays high until the last word, which shows in the cycle
// busy drops.
// Results cannot be held off: each word is valid for exactly one cycle.
// Configuration: keep_count at byte address 0 of the APB-style port, reset
// 8; write it only while idle. Reset empties the list at once.
module sorted_candidate_list_insert_unit
  import scli_pkg::*;
#(
  parameter int MAX_CANDIDATES = MaxCandidates
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  input  logic             start_i,
  input  in_word_t         in_word_i,
  output logic             busy_o,
  output logic             out_valid_o,
  output out_word_t        out_word_o
);

  localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;

  logic [KeepW-1:0] keep_count;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  slot_t            mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  slot_t            mem_rdata;

  scli_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .keep_count_o (keep_count)
  );

  scli_insert_ctrl #(
    .Depth (MAX_CANDIDATES)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .keep_count_i (keep_count),
    .start_i,
    .in_word_i,
    .busy_o,
    .out_valid_o,
    .out_word_o,
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  scli_slot_ram #(
    .Depth (MAX_CANDIDATES)
  ) u_ram (
    .clk_i,
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

[design/scli_checker.sv]
// Port-level checks on the result burst of the candidate list, with bind.
module scli_checker
  import scli_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      out_valid_o,
  input out_word_t out_word_o
);

  // a burst runs without gaps until its last word
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |=> out_valid_o)
    else $error("result burst broken before last word");

  // ranks count up by one inside a burst
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.rank != '0) |->
      $past(out_valid_o) && (($past(out_word_o.rank) + RankW'(1)) == out_word_o.rank))
    else $error("rank does not follow previous word");

  // a burst opens at rank zero
  a_rank_zero_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> (out_word_o.rank == '0))
    else $error("burst does not start at rank zero");

  // the unit is still busy while more words are due
  a_busy_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> busy_o)
    else $error("idle while result burst unfinished");

  // an accepted word keeps the unit busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted word did not raise busy");

endmodule

bind sorted_candidate_list_insert_unit scli_checker u_scli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .out_valid_o (out_valid_o),
  .out_word_o  (out_word_o)
);

[bench/sorted_candidate_list_insert_unit_test.sv]
// Testbench for the sorted candidate list: directed and random candidates checked word by word.
`timescale 1ns / 1ps

module sorted_candidate_list_insert_unit_test;
  import scli_pkg::*;

  localparam int          RandomItems = 360;
  localparam int          CycleLimit  = 300000;
  localparam int          QuietCycles = MaxCandidates + 4;
  localparam logic [AddrW-1:0] KeepAddr = AddrW'({RegKeepCount, 2'b00});

  // Tracks the retained list and the ranked words that an end of block will emit.
  class list_tracker;
    logic [KeepW-1:0] keep_count;
    logic [ModeW-1:0] mode_slot[MaxCandidates];
    logic [CostW-1:0] cost_slot[MaxCandidates];
    int unsigned      filled;
    out_word_t        ranked_due[$];
    int unsigned      failures;

    function new();
      keep_count = KeepReset;
      filled     = 0;
      failures   = 0;
    endfunction

    function int unsigned retained();
      int unsigned k;
      k = keep_count;
      if (k < 1) k = 1;
      if (k > OutLimit) k = OutLimit;
      if (k > MaxCandidates) k = MaxCandidates;
      return k;
    endfunction

    function void note_candidate(in_word_t w);
      int unsigned cap;
      int unsigned n;
      int unsigned pos;
      int unsigned i;
      out_word_t   r;
      cap = retained();
      n   = (filled > cap) ? cap : filled;
      // ties go behind every stored entry of equal cost
      pos = 0;
      while (pos < n && cost_slot[pos] <= w.cost) pos++;
      if (pos >= cap) begin
        filled = n;
      end else begin
        i = (n < cap) ? n : cap - 1;
        while (i > pos) begin
          mode_slot[i] = mode_slot[i-1];
          cost_slot[i] = cost_slot[i-1];
          i--;
        end
        mode_slot[pos] = w.mode;
        cost_slot[pos] = w.cost;
        filled = (n < cap) ? n + 1 : cap;
      end
      if (w.end_of_block) begin
        for (int unsigned k = 0; k < filled; k++) begin
          r.rank      = RankW'(k);
          r.best_mode = mode_slot[k];
          r.best_cost = cost_slot[k];
          r.last      = (k + 1 == filled);
          ranked_due.push_back(r);
        end
        filled = 0;
      end
    endfunction

    function void check_ranked_word(out_word_t got);
      out_word_t want;
      if (ranked_due.size() == 0) begin
        $error("unexpected word: rank %0d best_mode %0d best_cost %0h last %0b",
               got.rank, got.best_mode, got.best_cost, got.last);
        failures++;
        return;
      end
      want = ranked_due.pop_front();
      if (got.rank !== want.rank) begin
        $error("rank: expected %0d, actual %0d", want.rank, got.rank);
        failures++;
      end
      if (got.best_mode !== want.best_mode) begin
        $error("best_mode: expected %0d, actual %0d", want.best_mode, got.best_mode);
        failures++;
      end
      if (got.best_cost !== want.best_cost) begin
        $error("best_cost: expected %0h, actual %0h", want.best_cost, got.best_cost);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, got.last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return ranked_due.size();
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             start_i;
  in_word_t         in_word_i;
  logic             busy_o;
  logic             out_valid_o;
  out_word_t        out_word_o;

  list_tracker tracker = new();
  int unsigned cycles  = 0;

  sorted_candidate_list_insert_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .start_i     (start_i),
    .in_word_i   (in_word_i),
    .busy_o      (busy_o),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) tracker.note_candidate(in_word_i);
      if (out_valid_o) tracker.check_ranked_word(out_word_o);
    end
  end

  function automatic in_word_t make_word(logic [ModeW-1:0] m, logic [CostW-1:0] c, logic e);
    in_word_t w;
    w.mode         = m;
    w.cost         = c;
    w.end_of_block = e;
    return w;
  endfunction

  function automatic logic [CostW-1:0] draw_cost(int unsigned style);
    logic [CostW-1:0] c;
    case (style)
      0: begin
        c = CostW'($urandom_range(0, 7));
      end
      1: begin
        c = {8'($urandom), 32'($urandom)};
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       c = '0;
          1:       c = '1;
          2:       c = '1 - CostW'($urandom_range(0, 3));
          default: c = {8'($urandom), 32'($urandom)};
        endcase
      end
    endcase
    return c;
  endfunction

  // Present a word after the given gap and hold it until the unit takes it.
  task automatic push_word(in_word_t w, int unsigned gap);
    @(negedge clk_i);
    if (gap != 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i   = 1'b1;
    in_word_i = w;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start and wait until every expected word has arrived and the unit is idle.
  task automatic wait_list_quiet();
    @(negedge clk_i);
    start_i = 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_keep(logic [KeepW-1:0] k);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = KeepAddr;
    pwdata  = ($urandom & ~DataW'(4'hF)) | DataW'(k);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.keep_count = k;
    @(negedge clk_i);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== DataW'(k)) begin
      $error("keep_count: expected %0d, actual %0d", k, prdata);
      tracker.failures++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    in_word_t    directed[$];
    int unsigned keep_plan[$];
    int unsigned random_sent;
    int unsigned phase;
    int unsigned phase_len;
    int unsigned phase_sent;
    int unsigned block_len;
    int unsigned style;
    int unsigned wait_left;
    logic        calm;
    logic        eob;

    rst_ni    = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    start_i   = 1'b0;
    in_word_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_keep(4'd8);

    // lone entries at both cost extremes
    directed.push_back(make_word(8'd0, '0, 1'b1));
    directed.push_back(make_word(8'd255, '1, 1'b1));
    // equal costs keep their arrival order
    for (int i = 1; i <= 4; i++) directed.push_back(make_word(ModeW'(i), 40'd100, 1'b0));
    directed.push_back(make_word(8'd5, 40'd50, 1'b0));
    directed.push_back(make_word(8'd6, 40'd100, 1'b1));
    // full list: worse candidates drop, the last one still closes the block
    for (int i = 0; i < 8; i++) directed.push_back(make_word(ModeW'(10 + i), CostW'(10 * (i + 1)), 1'b0));
    directed.push_back(make_word(8'd99, '1, 1'b0));
    directed.push_back(make_word(8'd98, '1, 1'b1));
    // descending costs: every entry lands at the head
    for (int i = 5; i >= 1; i--) directed.push_back(make_word(ModeW'(40 + i), CostW'(i), i == 1));
    // leave three entries for the shrink below
    directed.push_back(make_word(8'd71, 40'd3, 1'b0));
    directed.push_back(make_word(8'd72, 40'd1, 1'b0));
    directed.push_back(make_word(8'd73, 40'd2, 1'b0));
    foreach (directed[i]) push_word(directed[i], (i % 3 == 0) ? $urandom_range(0, 7) : 0);

    // shrink while filled: entries past the new size go before the insertion
    wait_list_quiet();
    write_keep(4'd2);
    push_word(make_word(8'd74, 40'd0, 1'b1), 0);

    keep_plan = '{0, 15, 1, 3, 8, 5, 2, 7, 4, 6};
    random_sent = 0;
    phase = 0;
    while (random_sent < RandomItems) begin
      wait_list_quiet();
      write_keep((phase < keep_plan.size()) ? KeepW'(keep_plan[phase]) : KeepW'($urandom_range(0, 15)));
      phase++;
      calm       = ($urandom_range(0, 3) == 0);
      phase_len  = $urandom_range(12, 40);
      phase_sent = 0;
      while (phase_sent < phase_len) begin
        block_len = $urandom_range(1, 12);
        style     = $urandom_range(0, 2);
        for (int unsigned b = 0; b < block_len && phase_sent < phase_len; b++) begin
          // now and then leave a block open so it merges with the next one
          eob = (b + 1 == block_len) && ($urandom_range(0, 9) != 0);
          push_word(make_word(ModeW'($urandom), draw_cost(style), eob),
                    calm ? 0 : $urandom_range(0, 7));
          phase_sent++;
          random_sent++;
        end
      end
    end

    // close any open block, then drain
    push_word(make_word(ModeW'($urandom), draw_cost(1), 1'b1), 0);
    @(negedge clk_i);
    start_i = 1'b0;
    wait_left = 4000;
    while (tracker.pending() != 0 && wait_left != 0) begin
      @(posedge clk_i);
      wait_left--;
    end
    repeat (QuietCycles) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $error("%0d ranked words never arrived", tracker.pending());
      tracker.failures++;
    end

    if (tracker.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
design/scli_pkg.sv
design/scli_slot_ram.sv
design/scli_cfg_regs.sv
design/scli_insert_ctrl.sv
design/sorted_candidate_list_insert_unit.sv
design/scli_checker.sv
bench/sorted_candidate_list_insert_unit_test.sv
